@@ design/wsd_pkg.sv @@
// Shared types and codes for the WebSocket frame deframer.
package wsd_pkg;

	// Received byte with its start-of-buffer mark
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       rx_first;
	} in_item_t;

	// Unmasked payload byte or event
	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] out_kind;
		logic       out_last;
	} out_item_t;

	// Parser phases
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_LEN1    = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_KEY     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	// Result kinds
	localparam logic [2:0] KIND_PAYLOAD = 3'd0;
	localparam logic [2:0] KIND_PING    = 3'd1;
	localparam logic [2:0] KIND_CLOSE   = 3'd2;
	localparam logic [2:0] KIND_IGNORED = 3'd3;
	localparam logic [2:0] KIND_UNSUP   = 3'd4;
	localparam logic [2:0] KIND_EMPTY   = 3'd5;

	// Opcodes
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;

	// Seven-bit length escapes
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// Header byte counts
	localparam logic [2:0] EXTLEN_BYTES = 3'd2;
	localparam logic [2:0] KEY_BYTES    = 3'd4;

endpackage

@@ design/wsd_in_stage.sv @@
// Input register stage of the WebSocket frame deframer.
module wsd_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  wsd_pkg::in_item_t item,
	input  logic             free,
	output logic             valid_s1,
	output wsd_pkg::in_item_t item_s1
);
	import wsd_pkg::*;

	// Stall only while a held byte cannot move on
	assign item_stall = valid_s1 && !free;

	// Capture a new transaction, or drain when the parser takes the held one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (free) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold payload
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end
endmodule

@@ design/wsd_parser.sv @@
// Header parser and payload unmasking for the WebSocket frame deframer.
module wsd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  wsd_pkg::in_item_t item,
	output logic              emit,
	output wsd_pkg::out_item_t result
);
	import wsd_pkg::*;

	logic [2:0]  phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        final_q, final_d;
	logic        masked_q, masked_d;
	logic [15:0] len_q, len_d;
	logic [2:0]  hcnt_q, hcnt_d;
	logic [15:0] pcnt_q, pcnt_d;
	logic [31:0] key_q, key_d;

	// Compute one parser step on the held byte
	always_comb begin
		logic [7:0] b;
		logic [6:0] len7;
		logic       done;
		logic       ev;
		logic [2:0] ev_kind;
		logic [7:0] kb;
		logic       last;

		b        = item.rx_byte;
		len7     = b[6:0];
		done     = 1'b0;
		ev       = 1'b0;
		ev_kind  = KIND_IGNORED;
		kb       = 8'd0;
		last     = 1'b0;
		phase_d  = phase_q;
		opcode_d = opcode_q;
		final_d  = final_q;
		masked_d = masked_q;
		len_d    = len_q;
		hcnt_d   = hcnt_q;
		pcnt_d   = pcnt_q;
		key_d    = key_q;
		emit     = 1'b0;
		result   = '0;

		if (item.rx_first) begin
			// Restart on a buffer start
			final_d  = b[7];
			opcode_d = b[3:0];
			masked_d = 1'b0;
			len_d    = 16'd0;
			hcnt_d   = 3'd0;
			pcnt_d   = 16'd0;
			key_d    = 32'd0;
			phase_d  = PH_LEN1;
		end else begin
			case (phase_q)
				PH_LEN1: begin
					masked_d = b[7];
					if (!final_q) begin
						ev = 1'b1; ev_kind = KIND_IGNORED;
					end else if (opcode_q == OP_PING) begin
						ev = 1'b1; ev_kind = KIND_PING;
					end else if (opcode_q == OP_CLOSE) begin
						ev = 1'b1; ev_kind = KIND_CLOSE;
					end else if (opcode_q != OP_BINARY) begin
						ev = 1'b1; ev_kind = KIND_IGNORED;
					end else if (len7 == LEN_EXT64) begin
						ev = 1'b1; ev_kind = KIND_UNSUP;
					end else if (len7 == LEN_EXT16) begin
						len_d   = 16'd0;
						hcnt_d  = 3'd0;
						phase_d = PH_EXTLEN;
					end else begin
						len_d = {9'd0, len7};
						done  = 1'b1;
					end
				end
				PH_EXTLEN: begin
					// Shift in big-endian length bytes
					len_d  = {len_q[7:0], b};
					hcnt_d = hcnt_q + 3'd1;
					if (hcnt_d >= EXTLEN_BYTES) begin
						done = 1'b1;
					end
				end
				PH_KEY: begin
					// Place key byte by arrival order
					case (hcnt_q[1:0])
						2'd0:    key_d = key_q | {24'd0, b};
						2'd1:    key_d = key_q | {16'd0, b, 8'd0};
						2'd2:    key_d = key_q | {8'd0, b, 16'd0};
						default: key_d = key_q | {b, 24'd0};
					endcase
					hcnt_d = hcnt_q + 3'd1;
					if (hcnt_d >= KEY_BYTES) begin
						if (len_q == 16'd0) begin
							ev = 1'b1; ev_kind = KIND_EMPTY;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					// Unmask with key byte (index mod 4)
					case (pcnt_q[1:0])
						2'd0:    kb = key_q[7:0];
						2'd1:    kb = key_q[15:8];
						2'd2:    kb = key_q[23:16];
						default: kb = key_q[31:24];
					endcase
					pcnt_d = pcnt_q + 16'd1;
					last   = (pcnt_d == len_q);
					if (last) begin
						phase_d = PH_IDLE;
					end
					emit            = 1'b1;
					result.out_byte = b ^ kb;
					result.out_kind = KIND_PAYLOAD;
					result.out_last = last;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		// Length complete: go to key, payload, or report empty frame
		if (done) begin
			pcnt_d = 16'd0;
			hcnt_d = 3'd0;
			if (masked_d) begin
				key_d   = 32'd0;
				phase_d = PH_KEY;
			end else if (len_d == 16'd0) begin
				ev = 1'b1; ev_kind = KIND_EMPTY;
			end else begin
				phase_d = PH_PAYLOAD;
			end
		end

		// Drop the frame after an event
		if (ev) begin
			phase_d         = PH_IDLE;
			emit            = 1'b1;
			result.out_byte = 8'd0;
			result.out_kind = ev_kind;
			result.out_last = 1'b1;
		end
	end

	// Advance parser state when a byte is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			opcode_q <= 4'd0;
			final_q  <= 1'b0;
			masked_q <= 1'b0;
			len_q    <= 16'd0;
			hcnt_q   <= 3'd0;
			pcnt_q   <= 16'd0;
			key_q    <= 32'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			final_q  <= final_d;
			masked_q <= masked_d;
			len_q    <= len_d;
			hcnt_q   <= hcnt_d;
			pcnt_q   <= pcnt_d;
			key_q    <= key_d;
		end
	end
endmodule

@@ design/wsd_out_stage.sv @@
// Result register of the WebSocket frame deframer.
module wsd_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               emit,
	input  wsd_pkg::out_item_t result_d,
	output logic               free,
	output logic               result_valid,
	input  logic               result_stall,
	output wsd_pkg::out_item_t result
);
	import wsd_pkg::*;

	// Slot takes a new result when empty or being read this cycle
	assign free = !result_valid || !result_stall;

	// Load or drain the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (free) begin
			result_valid <= step && emit;
		end
	end

	// Hold payload until taken
	always_ff @(posedge clk) begin
		if (free && step && emit) begin
			result <= result_d;
		end
	end
endmodule

@@ design/websocket_frame_deframer.sv @@
// Top level of the WebSocket frame deframer.
// Usage:
//   item channel: one received byte per transaction (rx_byte) with rx_first
//   marking the start of a frame buffer; rx_first always restarts the parser.
//   result channel: unmasked payload bytes of final binary frames (kind 0,
//   out_last on the last byte) and single events for ping, close, ignored
//   frames, unsupported 64-bit lengths and empty binary frames.
// Path: input register, then parser into the result register.
// Throughput: one byte per cycle while the result register is not
//   stalled; header bytes yield no result, so the result rate is at
//   most one per cycle, set by the single parser step.
// Reset: arst_n clears both stage valid flags and returns the parser to
//   waiting for a first byte; bytes without rx_first are then dropped.
// Backpressure: while result_stall holds a full result register, the
//   parser holds, and item_stall rises once the input register is full;
//   nothing is lost or repeated.
module websocket_frame_deframer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  wsd_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output wsd_pkg::out_item_t result
);
	import wsd_pkg::*;

	logic      free;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      step;
	logic      emit;
	out_item_t result_d;

	// Parser runs when a byte is held and the result slot can take it
	assign step = valid_s1 && free;

	wsd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.free       (free),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	wsd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.emit   (emit),
		.result (result_d)
	);

	wsd_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.emit         (emit),
		.result_d     (result_d),
		.free         (free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Events always close the frame with a zero byte
	a_event_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.out_kind != KIND_PAYLOAD
			|-> result.out_last && result.out_byte == 8'd0)
		else $error("event result without last or with nonzero byte");

	// Input stalls only behind a blocked result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid && result_stall)
		else $error("input stalled without output backpressure");

	// Result kind stays within the defined codes
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.out_kind <= KIND_EMPTY)
		else $error("result kind out of range");

	// A result appears only after the parser stepped
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(step && emit))
		else $error("result appeared without a parser step");
endmodule
